### design/pts_pkg.sv
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared sizes, request and status codes, payload and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int PRIO_BITS = 8;
  localparam int DELAY_W   = 32;

  localparam logic [1:0] REQ_CREATE   = 2'd0;
  localparam logic [1:0] REQ_DELAY    = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;
  localparam logic [1:0] REQ_SCHEDULE = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_NO_CURRENT = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  task_priority;
    logic [31:0] delay_amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] current_task;
    logic       current_valid;
    logic [3:0] tasks_in_use;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic tick_step;
    logic sched_step;
  } pts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_tick;
    logic go_sched;
    logic scan_last;
  } pts_sts_t;

endpackage

`default_nettype wire

### design/pts_ctrl.sv
// ----------------------------------------------------------------------------
// Priority task scheduler controller
// Sequences accept, per-entry scan steps and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire pts_pkg::pts_sts_t sts,
  output pts_pkg::pts_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import pts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TICK  = 4'b0010,
    S_SCHED = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    cmd.accept     = accept;
    cmd.tick_step  = (state_r == S_TICK);
    cmd.sched_step = (state_r == S_SCHED);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.go_tick) begin
            state_nxt = S_TICK;
          end else if (sts.go_sched) begin
            state_nxt = S_SCHED;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_TICK, S_SCHED: begin
        if (sts.scan_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_resp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |=> state_r == S_IDLE)
    else $error("result strobe held longer than one cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted transaction did not start");

  a_scan_ends_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK || state_r == S_SCHED) && sts.scan_last |=> state_r == S_RESP)
    else $error("scan end did not produce a result");

endmodule

`default_nettype wire

### design/pts_dp.sv
// ----------------------------------------------------------------------------
// Priority task scheduler datapath
// Task table, scheduler registers, scan counter and the best-priority search.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pts_pkg::in_item_t in_data,
  input  wire pts_pkg::pts_cmd_t cmd,
  output pts_pkg::pts_sts_t  sts,
  output pts_pkg::out_item_t out_data
);
  import pts_pkg::*;

  // task table, entries valid below count_used_r
  logic                 task_blocked_r [MAX_TASKS];
  logic [DELAY_W-1:0]   delay_left_r   [MAX_TASKS];
  logic [PRIO_BITS-1:0] task_prio_r    [MAX_TASKS];

  logic [CNT_W-1:0]     count_used_r;
  logic [IDX_W-1:0]     current_index_r;
  logic                 have_current_r;
  logic [1:0]           status_r;

  logic [IDX_W-1:0]     scan_idx_r, scan_cnt_r;
  logic [PRIO_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]     chosen_r, chosen_nxt;
  logic                 found_r, found_nxt;

  logic                 is_full, cur_ok, rd_blocked;
  logic [DELAY_W-1:0]   rd_delay;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [IDX_W-1:0]     cur_inc, scan_inc;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] sum;
    sum = CNT_W'(idx) + CNT_W'(1);
    wrap_inc = (sum >= cnt) ? '0 : sum[IDX_W-1:0];
  endfunction

  assign is_full    = (count_used_r == CNT_W'(MAX_TASKS));
  assign cur_ok     = have_current_r && (CNT_W'(current_index_r) < count_used_r);
  assign rd_blocked = task_blocked_r[scan_idx_r];
  assign rd_delay   = delay_left_r[scan_idx_r];
  assign rd_prio    = task_prio_r[scan_idx_r];
  assign cur_inc    = wrap_inc(current_index_r, count_used_r);
  assign scan_inc   = wrap_inc(scan_idx_r, count_used_r);

  always_comb begin
    sts.go_tick   = (in_data.req_type == REQ_TICK) && (count_used_r != '0);
    sts.go_sched  = (in_data.req_type == REQ_SCHEDULE) && cur_ok;
    sts.scan_last = (CNT_W'(scan_cnt_r) + CNT_W'(1) == count_used_r);
  end

  // strictly greater keeps the first task met on a tie
  always_comb begin
    best_nxt   = best_r;
    chosen_nxt = chosen_r;
    found_nxt  = found_r;
    if (!rd_blocked && (!found_r || rd_prio > best_r)) begin
      best_nxt   = rd_prio;
      chosen_nxt = scan_idx_r;
      found_nxt  = 1'b1;
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_data.req_type == REQ_CREATE && !is_full) begin
        task_blocked_r[count_used_r[IDX_W-1:0]] <= 1'b0;
        delay_left_r[count_used_r[IDX_W-1:0]]   <= '0;
        task_prio_r[count_used_r[IDX_W-1:0]]    <= in_data.task_priority[PRIO_BITS-1:0];
      end else if (in_data.req_type == REQ_DELAY && cur_ok) begin
        delay_left_r[current_index_r]   <= in_data.delay_amount;
        task_blocked_r[current_index_r] <= 1'b1;
      end
    end else if (cmd.tick_step) begin
      if (rd_blocked && rd_delay != '0) begin
        delay_left_r[scan_idx_r] <= rd_delay - DELAY_W'(1);
        if (rd_delay == DELAY_W'(1)) begin
          task_blocked_r[scan_idx_r] <= 1'b0;
        end
      end
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_cnt_r <= '0;
      scan_idx_r <= (in_data.req_type == REQ_TICK) ? '0 : cur_inc;
      found_r    <= 1'b0;
      best_r     <= '0;
      chosen_r   <= '0;
      status_r   <= ST_OK;
      if (in_data.req_type == REQ_CREATE && is_full) begin
        status_r <= ST_FULL;
      end else if ((in_data.req_type == REQ_DELAY ||
                    in_data.req_type == REQ_SCHEDULE) && !cur_ok) begin
        status_r <= ST_NO_CURRENT;
      end
    end else if (cmd.tick_step || cmd.sched_step) begin
      scan_cnt_r <= scan_cnt_r + IDX_W'(1);
      scan_idx_r <= cmd.tick_step ? scan_idx_r + IDX_W'(1) : scan_inc;
      best_r     <= best_nxt;
      chosen_r   <= chosen_nxt;
      found_r    <= found_nxt;
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_used_r    <= '0;
      current_index_r <= '0;
      have_current_r  <= 1'b0;
    end else if (cmd.accept) begin
      if (in_data.req_type == REQ_CREATE && !is_full) begin
        if (count_used_r == '0) begin
          current_index_r <= '0;
          have_current_r  <= 1'b1;
        end
        count_used_r <= count_used_r + CNT_W'(1);
      end
    end else if (cmd.sched_step && sts.scan_last && found_nxt) begin
      current_index_r <= chosen_nxt;
    end
  end

  always_comb begin
    out_data.status        = status_r;
    out_data.current_task  = 3'(current_index_r);
    out_data.current_valid = have_current_r;
    out_data.tasks_in_use  = 4'(count_used_r);
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_used_r <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  a_current_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    have_current_r == (count_used_r != '0))
    else $error("current task flag out of step with task count");

  a_current_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    have_current_r |-> CNT_W'(current_index_r) < count_used_r)
    else $error("current task index outside the table");

endmodule

`default_nettype wire

### design/priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// Priority task scheduler core
// Task table with create, delay, tick and priority round-robin schedule.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. busy stays high from
//   the accept until the result cycle has ended.
//   Output: out_valid is high for exactly one cycle with out_data holding
//   status, current task, current-valid flag and task count. The receiver
//   must take it in that cycle; there is no backpressure.
//   Sequence: create, delay and requests that end at once (no tasks, no
//   current task) show the result in the cycle after the accept. Tick and
//   schedule walk the table one entry per cycle and show the result after
//   the last entry. One shared read port on the task table sets that rate;
//   a new transaction can be taken in the cycle after the result.
//   Reset: synchronous, active low; clears task count and current task.
//   The table entries need no clearing, only created entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire pts_pkg::in_item_t in_data,
  output logic                out_valid,
  output pts_pkg::out_item_t  out_data
);
  import pts_pkg::*;

  pts_cmd_t cmd;
  pts_sts_t sts;

  // sequence accept, scan steps and the result strobe
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold the task table and the scheduler registers
  pts_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
